// ===== rtl/clock_tree_frequency_calc_top_assert.svh =====
// Assertion macros for the clock tree frequency calculator RTL, used by ctfc_queue.
`ifndef CLOCK_TREE_FREQUENCY_CALC_TOP_ASSERT_SVH
`define CLOCK_TREE_FREQUENCY_CALC_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTFC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("ctfc assertion failed");

// Next-cycle implication, checked outside reset.
`define CTFC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("ctfc assertion failed");

`endif

// ===== rtl/ctfc_pkg.sv =====
// Shared types, constants and decode functions for the clock tree calculator.
package ctfc_pkg;

  localparam int HSE_W    = 26;
  localparam int WORD_W   = 32;
  localparam int RECIP_W  = 30;
  localparam int RECIP_SH = 29;
  localparam int PROD1_W  = HSE_W + RECIP_W;
  localparam int Q_W      = PROD1_W - RECIP_SH;
  localparam int N_W      = 7;
  localparam int AHB_SH_W = 4;
  localparam int APB_SH_W = 3;

  // x / 3 = (x * DIV3_RECIP) >> DIV3_SH, exact for x < 2^31
  localparam int DIV3_SH   = 31;
  localparam int DIV3_W    = 30;
  localparam int PROD3_W   = (WORD_W - 1) + DIV3_W;
  localparam logic [DIV3_W-1:0] DIV3_RECIP = 30'd715827883;

  localparam logic [HSE_W-1:0] HSE_RESET_HZ    = 26'd8000000;
  localparam logic [HSE_W-1:0] HSI16_HZ        = 26'd16000000;
  localparam logic [HSE_W-1:0] MSI_FALLBACK_HZ = 26'd4000000;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // PLL source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_HSI  = 2'd1;
  localparam logic [1:0] SRC_HSE  = 2'd2;
  localparam logic [1:0] SRC_MSI  = 2'd3;

  // switch status codes
  localparam logic [1:0] SWS_MSI = 2'd0;
  localparam logic [1:0] SWS_HSI = 2'd1;
  localparam logic [1:0] SWS_HSE = 2'd2;
  localparam logic [1:0] SWS_PLL = 2'd3;

  // R divider codes
  localparam logic [1:0] RDIV_2 = 2'd0;
  localparam logic [1:0] RDIV_4 = 2'd1;
  localparam logic [1:0] RDIV_6 = 2'd2;
  localparam logic [1:0] RDIV_8 = 2'd3;

  typedef struct packed {
    logic [N_W-1:0]      n;
    logic [1:0]          r_code;
    logic                use_pll;
    logic [HSE_W-1:0]    sys_base;
    logic [AHB_SH_W-1:0] ahb_sh;
    logic [APB_SH_W-1:0] apb1_sh;
    logic [APB_SH_W-1:0] apb2_sh;
  } ctl_t;

  typedef struct packed {
    logic [HSE_W-1:0] pll_in;
    logic [2:0]       m_code;
    ctl_t             ctl;
  } item_t;

  function automatic logic [HSE_W-1:0] msi_hz(input logic [3:0] code);
    logic [HSE_W-1:0] f;
    unique case (code)
      4'd0:    f = 26'd100000;
      4'd1:    f = 26'd200000;
      4'd2:    f = 26'd400000;
      4'd3:    f = 26'd800000;
      4'd4:    f = 26'd1000000;
      4'd5:    f = 26'd2000000;
      4'd6:    f = 26'd4000000;
      4'd7:    f = 26'd8000000;
      4'd8:    f = 26'd16000000;
      4'd9:    f = 26'd24000000;
      4'd10:   f = 26'd32000000;
      4'd11:   f = 26'd48000000;
      default: f = MSI_FALLBACK_HZ;
    endcase
    return f;
  endfunction

  // ceil(2^29 / M), exact quotient for inputs below 2^26
  function automatic logic [RECIP_W-1:0] m_recip(input logic [2:0] m_code);
    logic [RECIP_W-1:0] c;
    unique case (m_code)
      3'd0:    c = 30'd536870912;
      3'd1:    c = 30'd268435456;
      3'd2:    c = 30'd178956971;
      3'd3:    c = 30'd134217728;
      3'd4:    c = 30'd107374183;
      3'd5:    c = 30'd89478486;
      3'd6:    c = 30'd76695845;
      default: c = 30'd67108864;
    endcase
    return c;
  endfunction

  function automatic logic [AHB_SH_W-1:0] ahb_shift(input logic [3:0] code);
    logic [AHB_SH_W-1:0] s;
    unique case (code)
      4'd8:    s = 4'd1;
      4'd9:    s = 4'd2;
      4'd10:   s = 4'd3;
      4'd11:   s = 4'd4;
      4'd12:   s = 4'd6;
      4'd13:   s = 4'd7;
      4'd14:   s = 4'd8;
      4'd15:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [APB_SH_W-1:0] apb_shift(input logic [2:0] code);
    logic [APB_SH_W-1:0] s;
    unique case (code)
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd2;
      3'd6:    s = 3'd3;
      3'd7:    s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ctfc_front.sv =====
// Front end: HSE register, request decode and push into the queue.
module ctfc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ctfc_pkg::HSE_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_cr_word,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_cfgr_word,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_pllcfgr_word,
  output logic                          push_valid,
  input  logic                          push_ready,
  output ctfc_pkg::item_t               push_item
);

  logic [ctfc_pkg::HSE_W-1:0] hse_r;
  logic [ctfc_pkg::HSE_W-1:0] hse_nxt;
  logic [ctfc_pkg::HSE_W-1:0] msi;
  logic [1:0]                 src;
  logic [1:0]                 sws;

  assign hse_nxt = cfg_wr_en ? cfg_wr_data : hse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hse_r <= ctfc_pkg::HSE_RESET_HZ;
    end else begin
      hse_r <= hse_nxt;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign msi = ctfc_pkg::msi_hz(in_cr_word[7:4]);
  assign src = in_pllcfgr_word[1:0];
  assign sws = in_cfgr_word[3:2];

  always_comb begin
    push_item = '0;
    // no source gives a zero input, so the PLL path yields zero on its own
    unique case (src)
      ctfc_pkg::SRC_HSI: push_item.pll_in = ctfc_pkg::HSI16_HZ;
      ctfc_pkg::SRC_HSE: push_item.pll_in = hse_r;
      ctfc_pkg::SRC_MSI: push_item.pll_in = msi;
      default:           push_item.pll_in = '0;
    endcase
    push_item.m_code     = in_pllcfgr_word[6:4];
    push_item.ctl.n      = in_pllcfgr_word[14:8];
    push_item.ctl.r_code = in_pllcfgr_word[26:25];
    push_item.ctl.use_pll = (sws == ctfc_pkg::SWS_PLL);
    unique case (sws)
      ctfc_pkg::SWS_MSI: push_item.ctl.sys_base = msi;
      ctfc_pkg::SWS_HSI: push_item.ctl.sys_base = ctfc_pkg::HSI16_HZ;
      ctfc_pkg::SWS_HSE: push_item.ctl.sys_base = hse_r;
      default:           push_item.ctl.sys_base = '0;
    endcase
    push_item.ctl.ahb_sh  = ctfc_pkg::ahb_shift(in_cfgr_word[7:4]);
    push_item.ctl.apb1_sh = ctfc_pkg::apb_shift(in_cfgr_word[10:8]);
    push_item.ctl.apb2_sh = ctfc_pkg::apb_shift(in_cfgr_word[13:11]);
  end

endmodule

// ===== rtl/ctfc_queue.sv =====
// Small FIFO between the decode front end and the arithmetic back end.
`include "clock_tree_frequency_calc_top_assert.svh"

module ctfc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ctfc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ctfc_pkg::item_t pop_item
);

  ctfc_pkg::item_t                  mem_r [ctfc_pkg::QDEPTH];
  logic [ctfc_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ctfc_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [ctfc_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ctfc_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [ctfc_pkg::QCNT_W-1:0]      cnt_r;
  logic [ctfc_pkg::QCNT_W-1:0]      cnt_nxt;
  logic                             push;
  logic                             pop;

  assign push_ready = (cnt_r != ctfc_pkg::QCNT_W'(ctfc_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ctfc_pkg::QPTR_W'(ctfc_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ctfc_pkg::QPTR_W'(ctfc_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `CTFC_ASSERT_NOW(a_q_no_overflow, clk, rst_n, push && !pop, cnt_r != ctfc_pkg::QCNT_W'(ctfc_pkg::QDEPTH))
  `CTFC_ASSERT_NOW(a_q_no_underflow, clk, rst_n, pop, cnt_r != '0)
  `CTFC_ASSERT_NEXT(a_q_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `CTFC_ASSERT_NEXT(a_q_cnt_down, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ===== rtl/ctfc_back.sv =====
// Back end: four-stage PLL arithmetic and bus prescaler pipeline.
module ctfc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  ctfc_pkg::item_t             pop_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ctfc_pkg::WORD_W-1:0] out_sysclk_hz,
  output logic [ctfc_pkg::WORD_W-1:0] out_pll_hz,
  output logic [ctfc_pkg::WORD_W-1:0] out_pclk1_hz,
  output logic [ctfc_pkg::WORD_W-1:0] out_pclk2_hz
);

  localparam int W = ctfc_pkg::WORD_W;

  // stage 1: input * ceil(2^29/M)
  logic                           s1_v_r;
  logic [ctfc_pkg::PROD1_W-1:0]   s1_prod_r;
  ctfc_pkg::ctl_t                 s1_ctl_r;
  // stage 2: (input / M) * N, wrapping
  logic                           s2_v_r;
  logic [W-1:0]                   s2_vco_r;
  ctfc_pkg::ctl_t                 s2_ctl_r;
  // stage 3: (vco / 2) * ceil(2^31/3) for the divide-by-6 case
  logic                           s3_v_r;
  logic [W-1:0]                   s3_vco_r;
  logic [ctfc_pkg::PROD3_W-1:0]   s3_prod_r;
  ctfc_pkg::ctl_t                 s3_ctl_r;
  // stage 4: output register
  logic                           o_v_r;
  logic [W-1:0]                   o_sys_r;
  logic [W-1:0]                   o_pll_r;
  logic [W-1:0]                   o_p1_r;
  logic [W-1:0]                   o_p2_r;

  logic         rdy1, rdy2, rdy3, rdy4;
  logic [ctfc_pkg::Q_W-1:0] q_m;
  logic [W-1:0] pll_nxt;
  logic [W-1:0] sys_nxt;
  logic [W-1:0] hclk;

  assign rdy4 = !o_v_r || out_ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign pop_ready = rdy1;

  assign q_m = s1_prod_r[ctfc_pkg::PROD1_W-1:ctfc_pkg::RECIP_SH];

  always_comb begin
    unique case (s3_ctl_r.r_code)
      ctfc_pkg::RDIV_2: pll_nxt = s3_vco_r >> 1;
      ctfc_pkg::RDIV_4: pll_nxt = s3_vco_r >> 2;
      ctfc_pkg::RDIV_6: pll_nxt = W'(s3_prod_r[ctfc_pkg::PROD3_W-1:ctfc_pkg::DIV3_SH]);
      default:          pll_nxt = s3_vco_r >> 3;
    endcase
    sys_nxt = s3_ctl_r.use_pll ? pll_nxt : W'(s3_ctl_r.sys_base);
    hclk    = sys_nxt >> s3_ctl_r.ahb_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= pop_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) o_v_r  <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && pop_valid) begin
      s1_prod_r <= pop_item.pll_in * ctfc_pkg::m_recip(pop_item.m_code);
      s1_ctl_r  <= pop_item.ctl;
    end
    if (rdy2 && s1_v_r) begin
      s2_vco_r <= W'(q_m) * W'(s1_ctl_r.n);
      s2_ctl_r <= s1_ctl_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_vco_r  <= s2_vco_r;
      s3_prod_r <= s2_vco_r[W-1:1] * ctfc_pkg::DIV3_RECIP;
      s3_ctl_r  <= s2_ctl_r;
    end
    if (rdy4 && s3_v_r) begin
      o_pll_r <= pll_nxt;
      o_sys_r <= sys_nxt;
      o_p1_r  <= hclk >> s3_ctl_r.apb1_sh;
      o_p2_r  <= hclk >> s3_ctl_r.apb2_sh;
    end
  end

  assign out_valid     = o_v_r;
  assign out_sysclk_hz = o_sys_r;
  assign out_pll_hz    = o_pll_r;
  assign out_pclk1_hz  = o_p1_r;
  assign out_pclk2_hz  = o_p2_r;

endmodule

// ===== rtl/clock_tree_frequency_calc_top.sv =====
// Top level of the clock tree frequency calculator.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   request   | in_valid / in_ready  | in_cr_word, in_cfgr_word, in_pllcfgr_word
//   result    | out_valid / out_ready| out_sysclk_hz, out_pll_hz, out_pclk1_hz, out_pclk2_hz
//   config    | cfg_wr_en            | cfg_wr_data (HSE frequency, 26 bits)
//
// One request per cycle sustained while out_ready stays high; each result passes through
// the queue entry, three multiply stages and the output register before out_valid rises.
// The 2-entry queue lets requests be taken while the result side is stalled.
// Reset is synchronous, active low; HSE resets to 8 MHz.
// in_ready drops only when the queue and all back-end stages are full.
module clock_tree_frequency_calc_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ctfc_pkg::HSE_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_cr_word,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_cfgr_word,
  input  logic [ctfc_pkg::WORD_W-1:0]   in_pllcfgr_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctfc_pkg::WORD_W-1:0]   out_sysclk_hz,
  output logic [ctfc_pkg::WORD_W-1:0]   out_pll_hz,
  output logic [ctfc_pkg::WORD_W-1:0]   out_pclk1_hz,
  output logic [ctfc_pkg::WORD_W-1:0]   out_pclk2_hz
);

  logic            push_valid;
  logic            push_ready;
  ctfc_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  ctfc_pkg::item_t pop_item;

  ctfc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cr_word      (in_cr_word),
    .in_cfgr_word    (in_cfgr_word),
    .in_pllcfgr_word (in_pllcfgr_word),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  ctfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ctfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sysclk_hz (out_sysclk_hz),
    .out_pll_hz    (out_pll_hz),
    .out_pclk1_hz  (out_pclk1_hz),
    .out_pclk2_hz  (out_pclk2_hz)
  );

endmodule

// ===== tb/tb_clock_tree_frequency_calc_top.sv =====
// Self-checking testbench for the clock tree frequency calculator, with a scoreboard.
module tb_clock_tree_frequency_calc_top;
  import ctfc_pkg::*;

  localparam int LATENCY        = 5;
  localparam int N_PHASES       = 7;
  localparam int RAND_PER_PHASE = 178;

  typedef struct packed {
    logic [31:0] cr;
    logic [31:0] cfgr;
    logic [31:0] pllcfgr;
  } clk_req_t;

  typedef struct packed {
    logic [31:0] sysclk;
    logic [31:0] pll;
    logic [31:0] pclk1;
    logic [31:0] pclk2;
  } clk_freqs_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [HSE_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] in_cr_word = '0;
  logic [WORD_W-1:0] in_cfgr_word = '0;
  logic [WORD_W-1:0] in_pllcfgr_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_sysclk_hz;
  logic [WORD_W-1:0] out_pll_hz;
  logic [WORD_W-1:0] out_pclk1_hz;
  logic [WORD_W-1:0] out_pclk2_hz;

  clk_req_t         req_q[$];
  clk_freqs_t       freq_q[$];
  logic [HSE_W-1:0] hse_setting = HSE_RESET_HZ;
  logic [HSE_W-1:0] hse_plan [N_PHASES];
  bit               quiet = 1'b0;
  int               tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
  int               n_sent = 0, n_recv = 0, err_cnt = 0;

  clock_tree_frequency_calc_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cr_word     (in_cr_word),
    .in_cfgr_word   (in_cfgr_word),
    .in_pllcfgr_word(in_pllcfgr_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sysclk_hz  (out_sysclk_hz),
    .out_pll_hz     (out_pll_hz),
    .out_pclk1_hz   (out_pclk1_hz),
    .out_pclk2_hz   (out_pclk2_hz)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] msi_range_hz(input logic [3:0] code);
    logic [31:0] hz;
    case (code)
      4'd0:    hz = 32'd100000;
      4'd1:    hz = 32'd200000;
      4'd2:    hz = 32'd400000;
      4'd3:    hz = 32'd800000;
      4'd4:    hz = 32'd1000000;
      4'd5:    hz = 32'd2000000;
      4'd6:    hz = 32'd4000000;
      4'd7:    hz = 32'd8000000;
      4'd8:    hz = 32'd16000000;
      4'd9:    hz = 32'd24000000;
      4'd10:   hz = 32'd32000000;
      4'd11:   hz = 32'd48000000;
      default: hz = 32'd4000000;
    endcase
    return hz;
  endfunction

  // AHB prescaler skips divide-by-32
  function automatic logic [31:0] hclk_div(input logic [3:0] code);
    logic [31:0] d;
    case (code)
      4'd8:    d = 32'd2;
      4'd9:    d = 32'd4;
      4'd10:   d = 32'd8;
      4'd11:   d = 32'd16;
      4'd12:   d = 32'd64;
      4'd13:   d = 32'd128;
      4'd14:   d = 32'd256;
      4'd15:   d = 32'd512;
      default: d = 32'd1;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] pclk_div(input logic [2:0] code);
    return code[2] ? (32'd2 << code[1:0]) : 32'd1;
  endfunction

  function automatic clk_freqs_t predict_clocks(input clk_req_t rq, input logic [HSE_W-1:0] hse);
    logic [31:0] msi, src_hz, m, n, r, hclk;
    clk_freqs_t  f;
    msi = msi_range_hz(rq.cr[7:4]);
    m   = 32'(rq.pllcfgr[6:4]) + 32'd1;
    n   = 32'(rq.pllcfgr[14:8]);
    r   = (32'(rq.pllcfgr[26:25]) + 32'd1) * 32'd2;
    case (rq.pllcfgr[1:0])
      SRC_HSI: src_hz = 32'(HSI16_HZ);
      SRC_HSE: src_hz = 32'(hse);
      SRC_MSI: src_hz = msi;
      default: src_hz = 32'd0;
    endcase
    // product wraps at 32 bits before the R divide
    f.pll = ((src_hz / m) * n) / r;
    case (rq.cfgr[3:2])
      SWS_MSI: f.sysclk = msi;
      SWS_HSI: f.sysclk = 32'(HSI16_HZ);
      SWS_HSE: f.sysclk = 32'(hse);
      default: f.sysclk = f.pll;
    endcase
    hclk    = f.sysclk / hclk_div(rq.cfgr[7:4]);
    f.pclk1 = hclk / pclk_div(rq.cfgr[10:8]);
    f.pclk2 = hclk / pclk_div(rq.cfgr[13:11]);
    return f;
  endfunction

  function automatic logic [31:0] cfgr_of(input logic [1:0] sws, input logic [3:0] ahb,
                                          input logic [2:0] apb1, input logic [2:0] apb2);
    logic [31:0] w;
    w = '0;
    w[3:2] = sws;
    w[7:4] = ahb;
    w[10:8] = apb1;
    w[13:11] = apb2;
    return w;
  endfunction

  function automatic logic [31:0] pllcfgr_of(input logic [1:0] src, input logic [2:0] m_code,
                                             input logic [6:0] n, input logic [1:0] r_code);
    logic [31:0] w;
    w = '0;
    w[1:0] = src;
    w[6:4] = m_code;
    w[14:8] = n;
    w[26:25] = r_code;
    return w;
  endfunction

  function automatic clk_req_t random_req();
    clk_req_t rq;
    rq.cr = $urandom;
    rq.cfgr = $urandom;
    rq.pllcfgr = $urandom;
    case ($urandom_range(0, 9))
      0: rq.pllcfgr[14:8] = 7'd0;
      1: rq.pllcfgr[14:8] = 7'h7F;
      2: begin
        // clean words: only the decoded fields set
        rq.cr = 32'(rq.cr[7:4]) << 4;
        rq.cfgr = cfgr_of(rq.cfgr[3:2], rq.cfgr[7:4], rq.cfgr[10:8], rq.cfgr[13:11]);
        rq.pllcfgr = pllcfgr_of(rq.pllcfgr[1:0], rq.pllcfgr[6:4], rq.pllcfgr[14:8],
                                rq.pllcfgr[26:25]);
      end
      default: ;
    endcase
    return rq;
  endfunction

  task automatic queue_directed();
    clk_req_t rq;
    req_q.push_back('0);
    req_q.push_back('1);
    // walk every MSI range, switch source, PLL source, M, R and both prescalers
    for (int k = 0; k < 16; k++) begin
      rq.cr = (32'(k) << 4) | (k[0] ? 32'hFFFF_FF0F : 32'h0);
      rq.cfgr = cfgr_of(2'(k), 4'(15 - k), 3'(k), 3'(7 - k));
      rq.pllcfgr = pllcfgr_of(2'(k / 4), 3'(k), (k == 0) ? 7'd0 : (k == 15) ? 7'h7F : 7'(k * 8),
                              2'(k + k / 4));
      req_q.push_back(rq);
    end
    // 48 MHz MSI times N=127 overflows 32 bits
    rq.cr = 32'd11 << 4;
    rq.cfgr = cfgr_of(SWS_PLL, 4'd0, 3'd7, 3'd4);
    rq.pllcfgr = pllcfgr_of(SRC_MSI, 3'd0, 7'h7F, RDIV_2);
    req_q.push_back(rq);
    rq.cr = '0;
    rq.cfgr = cfgr_of(SWS_PLL, 4'd15, 3'd0, 3'd3);
    rq.pllcfgr = pllcfgr_of(SRC_HSI, 3'd7, 7'h7F, RDIV_8);
    req_q.push_back(rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || freq_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d", n_recv, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive
    clk_req_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        rq = req_q.pop_front();
        in_valid <= 1'b1;
        in_cr_word <= rq.cr;
        in_cfgr_word <= rq.cfgr;
        in_pllcfgr_word <= rq.pllcfgr;
        if (tx_calm > 0) begin
          tx_calm--;
        end else if (!quiet) begin
          case ($urandom_range(0, 9))
            0, 1, 2: tx_gap = $urandom_range(1, 16);
            3:       tx_calm = $urandom_range(30, 120);
            default: ;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else if (!quiet) begin
        case ($urandom_range(0, 15))
          0, 1:    rx_stall = $urandom_range(1, 16);
          2:       rx_calm = $urandom_range(30, 120);
          default: ;
        endcase
      end
    end
  end

  // scoreboard: predict on request accept, compare on result accept
  always @(posedge clk) begin : score
    clk_freqs_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        freq_q.push_back(predict_clocks(clk_req_t'({in_cr_word, in_cfgr_word, in_pllcfgr_word}),
                                        hse_setting));
        n_sent++;
      end
      if (out_valid && out_ready) begin
        n_recv++;
        if (freq_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result %0d with nothing pending", n_recv);
        end else begin
          want = freq_q.pop_front();
          check_field("sysclk_hz", want.sysclk, out_sysclk_hz);
          check_field("pll_hz", want.pll, out_pll_hz);
          check_field("pclk1_hz", want.pclk1, out_pclk1_hz);
          check_field("pclk2_hz", want.pclk2, out_pclk2_hz);
        end
      end
    end
  end

  initial begin
    hse_plan[0] = HSE_RESET_HZ;
    hse_plan[1] = 26'd48000000;
    hse_plan[2] = 26'd4000000;
    hse_plan[3] = 26'h3FF_FFFF;
    hse_plan[4] = 26'd0;
    hse_plan[5] = 26'($urandom_range(4000000, 48000000));
    hse_plan[6] = 26'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        // HSE only changes with the pipe empty
        wait_drained();
        repeat (LATENCY + 3) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hse_plan[p];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        hse_setting = hse_plan[p];
      end
      @(negedge clk);
      quiet = (p == N_PHASES - 1);
      if (p == 0) queue_directed();
      for (int i = 0; i < RAND_PER_PHASE; i++) req_q.push_back(random_req());
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d requests, %0d results checked over %0d HSE settings", n_sent, n_recv, N_PHASES);
    $display("settings: reset, 48 MHz, 4 MHz, 26-bit max, zero, two random");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout: %0d requests sent, %0d results seen", n_sent, n_recv);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ctfc_pkg.sv
rtl/ctfc_front.sv
rtl/ctfc_queue.sv
rtl/ctfc_back.sv
rtl/clock_tree_frequency_calc_top.sv
tb/tb_clock_tree_frequency_calc_top.sv
